### design/vector_distance_nearest_search_unit_macros.svh
// Assertion helpers shared by the distance search unit.
`ifndef VECTOR_DISTANCE_NEAREST_SEARCH_UNIT_MACROS_SVH
`define VECTOR_DISTANCE_NEAREST_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define VDNS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Concurrent assertion on the block clock and reset.
`define VDNS_ASSERT(lbl, prop, msg) \
  `VDNS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define VDNS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define VDNS_ASSERT(lbl, prop, msg)
`endif

`endif

### design/vdns_pkg.sv
package vdns_pkg;

  localparam int ACC_W      = 48;
  localparam int IDX_W      = 16;
  localparam int ELEM_WIDTH = 16;
  localparam int VEC_MAX    = 65536;

  typedef enum logic [1:0] {
    METRIC_L2   = 2'd0,
    METRIC_L1   = 2'd1,
    METRIC_LINF = 2'd2,
    METRIC_IP   = 2'd3
  } metric_e;

  // Framing flags that travel with each element pair.
  typedef struct packed {
    logic last_elem;
    logic last_vector;
  } frame_t;

endpackage

### design/vdns_in_stage.sv
module vdns_in_stage #(
  parameter int ElemWidth = vdns_pkg::ELEM_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ElemWidth-1:0] query_elem_i,
  input  logic signed [ElemWidth-1:0] cand_elem_i,
  input  logic                        last_elem_i,
  input  logic                        last_vector_i,
  input  logic                        out_free_i,
  output logic                        adv_o,
  output logic signed [ElemWidth-1:0] query_o,
  output logic signed [ElemWidth-1:0] cand_o,
  output vdns_pkg::frame_t            frame_o
);

  logic                        valid_q, valid_d;
  logic signed [ElemWidth-1:0] query_q;
  logic signed [ElemWidth-1:0] cand_q;
  vdns_pkg::frame_t            frame_q;
  logic                        accept;

  // A word that ends no candidate never needs the result register.
  assign adv_o      = valid_q && (!frame_q.last_elem || out_free_i);
  assign in_ready_o = !valid_q || adv_o;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q             <= query_elem_i;
      cand_q              <= cand_elem_i;
      frame_q.last_elem   <= last_elem_i;
      frame_q.last_vector <= last_vector_i;
    end
  end

  assign query_o = query_q;
  assign cand_o  = cand_q;
  assign frame_o = frame_q;

endmodule

### design/vdns_accum.sv
`include "vector_distance_nearest_search_unit_macros.svh"

module vdns_accum #(
  parameter int ElemWidth = vdns_pkg::ELEM_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_data_i,
  input  logic                              adv_i,
  input  logic signed [ElemWidth-1:0]       query_i,
  input  logic signed [ElemWidth-1:0]       cand_i,
  input  vdns_pkg::frame_t                  frame_i,
  output logic signed [vdns_pkg::ACC_W-1:0] acc_next_o
);

  localparam int AccW  = vdns_pkg::ACC_W;
  localparam int ProdW = 2 * ElemWidth + 2;
  localparam int SumW  = ((ProdW > AccW) ? ProdW : AccW) + 1;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  vdns_pkg::metric_e           metric_q;
  logic signed [AccW-1:0]      acc_q, acc_d;
  logic signed [ElemWidth:0]   q_ext, c_ext, diff;
  logic        [ElemWidth:0]   abs_diff;
  logic signed [ElemWidth:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]     prod;
  logic signed [SumW-1:0]      term, sum;
  logic        [SumW-AccW:0]   sum_top;
  logic signed [AccW-1:0]      sum_sat;
  logic signed [AccW-1:0]      abs_wide;

  assign q_ext    = {query_i[ElemWidth-1], query_i};
  assign c_ext    = {cand_i[ElemWidth-1], cand_i};
  assign diff     = q_ext - c_ext;
  assign abs_diff = diff[ElemWidth] ? (~diff + 1'b1) : diff;
  assign abs_wide = {{(AccW-ElemWidth-1){1'b0}}, abs_diff};

  // One multiplier serves both the squared difference and the inner product.
  assign mul_a = (metric_q == vdns_pkg::METRIC_IP) ? q_ext : diff;
  assign mul_b = (metric_q == vdns_pkg::METRIC_IP) ? c_ext : diff;
  assign prod  = mul_a * mul_b;

  always_comb begin
    if (metric_q == vdns_pkg::METRIC_L1) begin
      term = {{(SumW-ElemWidth-1){1'b0}}, abs_diff};
    end else begin
      term = {{(SumW-ProdW){prod[ProdW-1]}}, prod};
    end
  end

  assign sum     = {{(SumW-AccW){acc_q[AccW-1]}}, acc_q} + term;
  assign sum_top = sum[SumW-1:AccW-1];

  always_comb begin
    if ((&sum_top) || !(|sum_top)) begin
      sum_sat = sum[AccW-1:0];
    end else if (sum[SumW-1]) begin
      sum_sat = AccMin;
    end else begin
      sum_sat = AccMax;
    end
  end

  always_comb begin
    unique case (metric_q)
      vdns_pkg::METRIC_L2: acc_next_o = sum_sat;
      vdns_pkg::METRIC_L1: acc_next_o = sum_sat;
      vdns_pkg::METRIC_LINF: begin
        acc_next_o = (abs_wide > acc_q) ? abs_wide : acc_q;
      end
      default: acc_next_o = sum_sat;
    endcase
  end

  assign acc_d = frame_i.last_elem ? '0 : acc_next_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vdns_pkg::METRIC_L2;
      acc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        metric_q <= vdns_pkg::metric_e'(cfg_data_i);
      end
      if (adv_i) begin
        acc_q <= acc_d;
      end
    end
  end

  `VDNS_ASSERT(a_acc_clear, adv_i && frame_i.last_elem |=> acc_q == '0, "acc not cleared")
  `VDNS_ASSERT(a_acc_sum_grows, adv_i && (metric_q == vdns_pkg::METRIC_L1 || metric_q == vdns_pkg::METRIC_L2) |-> acc_next_o >= acc_q, "distance sum shrank")
  `VDNS_ASSERT(a_acc_max_grows, adv_i && metric_q == vdns_pkg::METRIC_LINF |-> acc_next_o >= acc_q, "running max shrank")

endmodule

### design/vdns_argmin.sv
`include "vector_distance_nearest_search_unit_macros.svh"

module vdns_argmin #(
  parameter int VecMax = vdns_pkg::VEC_MAX
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic signed [vdns_pkg::ACC_W-1:0] dist_i,
  input  logic                              last_vector_i,
  input  logic                              out_ready_i,
  output logic                              out_free_o,
  output logic                              out_valid_o,
  output logic signed [vdns_pkg::ACC_W-1:0] distance_o,
  output logic        [vdns_pkg::IDX_W-1:0] vector_index_o,
  output logic        [vdns_pkg::IDX_W-1:0] best_index_o,
  output logic signed [vdns_pkg::ACC_W-1:0] best_distance_o,
  output logic                              set_done_o
);

  localparam int AccW = vdns_pkg::ACC_W;
  localparam int IdxW = vdns_pkg::IDX_W;

  logic                   out_v_q;
  logic                   first_q;
  logic        [IdxW-1:0] cnt_q, cnt_d;
  logic signed [AccW-1:0] min_q;
  logic        [IdxW-1:0] min_idx_q;
  logic        [IdxW:0]   cnt_inc;
  logic                   better;
  logic signed [AccW-1:0] new_min;
  logic        [IdxW-1:0] new_idx;
  logic signed [AccW-1:0] dist_q;
  logic        [IdxW-1:0] vidx_q;
  logic        [IdxW-1:0] bidx_q;
  logic signed [AccW-1:0] bdist_q;
  logic                   done_q;

  assign out_free_o = !out_v_q || out_ready_i;

  // The first candidate of a set always wins; later ones only when strictly smaller.
  assign better  = first_q || (dist_i < min_q);
  assign new_min = better ? dist_i : min_q;
  assign new_idx = better ? cnt_q : min_idx_q;

  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    if (32'(cnt_inc) >= 32'(VecMax)) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_inc[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      first_q   <= 1'b1;
      cnt_q     <= '0;
      min_q     <= '0;
      min_idx_q <= '0;
    end else begin
      if (wr_en_i) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (wr_en_i) begin
        if (last_vector_i) begin
          first_q   <= 1'b1;
          cnt_q     <= '0;
          min_q     <= '0;
          min_idx_q <= '0;
        end else begin
          first_q   <= 1'b0;
          cnt_q     <= cnt_d;
          min_q     <= new_min;
          min_idx_q <= new_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      dist_q  <= dist_i;
      vidx_q  <= cnt_q;
      bidx_q  <= new_idx;
      bdist_q <= new_min;
      done_q  <= last_vector_i;
    end
  end

  assign out_valid_o     = out_v_q;
  assign distance_o      = dist_q;
  assign vector_index_o  = vidx_q;
  assign best_index_o    = bidx_q;
  assign best_distance_o = bdist_q;
  assign set_done_o      = done_q;

  `VDNS_ASSERT(a_no_overwrite, wr_en_i && out_v_q |-> out_ready_i, "result overwritten")
  `VDNS_ASSERT(a_set_restart, wr_en_i && last_vector_i |=> first_q && cnt_q == '0, "set not restarted")
  `VDNS_ASSERT(a_set_continue, wr_en_i && !last_vector_i |=> !first_q, "first flag kept")
  `VDNS_ASSERT(a_best_bound, out_v_q |-> bdist_q <= dist_q, "best above own distance")

endmodule

### design/vector_distance_nearest_search_unit.sv
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    query_elem, cand_elem, last_elem, last_vector
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (metric)
// out      output     out_valid_o / out_ready_i  distance, indexes, best distance, set_done
//
// One pair per cycle unless a closing word waits; the multiply-accumulate loop is unpipelined.
// A closing word is registered at input, then its result in the output register, unless the
// output register still holds an unread result.
// A word that closes a candidate waits in the input register while the output is full;
// other words pass without waiting. Reset clears the accumulator, search state and metric.
// The configuration port is always ready and needs no clearing pass.
module vector_distance_nearest_search_unit #(
  parameter int ElemWidth = vdns_pkg::ELEM_WIDTH,
  parameter int VecMax    = vdns_pkg::VEC_MAX
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ElemWidth-1:0]       query_elem_i,
  input  logic signed [ElemWidth-1:0]       cand_elem_i,
  input  logic                              last_elem_i,
  input  logic                              last_vector_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [vdns_pkg::ACC_W-1:0] distance_o,
  output logic        [vdns_pkg::IDX_W-1:0] vector_index_o,
  output logic        [vdns_pkg::IDX_W-1:0] best_index_o,
  output logic signed [vdns_pkg::ACC_W-1:0] best_distance_o,
  output logic                              set_done_o
);

  logic                              adv;
  logic                              out_free;
  logic signed [ElemWidth-1:0]       query;
  logic signed [ElemWidth-1:0]       cand;
  vdns_pkg::frame_t                  frame;
  logic signed [vdns_pkg::ACC_W-1:0] acc_next;

  assign cfg_ready_o = 1'b1;

  vdns_in_stage #(
    .ElemWidth(ElemWidth)
  ) u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .query_elem_i (query_elem_i),
    .cand_elem_i  (cand_elem_i),
    .last_elem_i  (last_elem_i),
    .last_vector_i(last_vector_i),
    .out_free_i   (out_free),
    .adv_o        (adv),
    .query_o      (query),
    .cand_o       (cand),
    .frame_o      (frame)
  );

  vdns_accum #(
    .ElemWidth(ElemWidth)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .adv_i     (adv),
    .query_i   (query),
    .cand_i    (cand),
    .frame_i   (frame),
    .acc_next_o(acc_next)
  );

  vdns_argmin #(
    .VecMax(VecMax)
  ) u_argmin (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (adv && frame.last_elem),
    .dist_i         (acc_next),
    .last_vector_i  (frame.last_vector),
    .out_ready_i    (out_ready_i),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .distance_o     (distance_o),
    .vector_index_o (vector_index_o),
    .best_index_o   (best_index_o),
    .best_distance_o(best_distance_o),
    .set_done_o     (set_done_o)
  );

endmodule
